>>> rtl/oq_pkg.sv
// shared types, codes and command/status structs for the ordered queue
package oq_pkg;

  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_KEY_WIDTH = 32;
  localparam int FIELD_W       = 32;
  localparam int COUNT_W       = 7;

  typedef enum logic [2:0] {
    MODE_INSERT     = 3'd0,
    MODE_POP        = 3'd1,
    MODE_POP_MATCH  = 3'd2,
    MODE_PEEK       = 3'd3,
    MODE_FIND_MATCH = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_ALLOC, S_FIRST, S_APPEND, S_ORD_WALK,
    S_ORD_LINK, S_HEAD, S_MATCH, S_MATCH_FREE, S_FINISH
  } state_t;

  typedef enum logic [2:0] {
    CUR_HOLD, CUR_ZERO, CUR_INC, CUR_HEAD, CUR_FREE, CUR_LINK
  } cur_sel_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_INIT_WR, ACT_ALLOC, ACT_FIRST, ACT_APPEND, ACT_ORD_STOP,
    ACT_ORD_LINK, ACT_POP, ACT_MATCH_HIT, ACT_MATCH_FREE
  } act_t;

  typedef struct packed {
    act_t     act;
    cur_sel_t cur_sel;
    logic     ld_op;
    logic     walk_start;
    logic     walk_step;
    logic     res_cap;
    logic     res_ld;
    status_t  res_st;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  ordering;
    logic  key_gt;
    logic  data_eq;
    logic  last;
    logic  init_last;
    logic  have_prev;
    logic  out_free;
  } stat_t;

endpackage

>>> rtl/oq_if.sv
// request and response channel interfaces
interface oq_req_if;
  import oq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [2:0]                mode;
  logic signed [FIELD_W-1:0] key;
  logic [FIELD_W-1:0]        item_data;
  modport source (output valid, mode, key, item_data, input ready);
  modport sink (input valid, mode, key, item_data, output ready);
endinterface

interface oq_rsp_if;
  import oq_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [FIELD_W-1:0] found_key;
  logic [FIELD_W-1:0]        found_data;
  logic [COUNT_W-1:0]        entry_count;
  modport source (output valid, status, found_key, found_data, entry_count, input ready);
  modport sink (input valid, status, found_key, found_data, entry_count, output ready);
endinterface

>>> rtl/oq_ctrl.sv
// sequencer for the ordered queue
module oq_ctrl import oq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '{act: ACT_NONE, cur_sel: CUR_HOLD, res_st: ST_OK, default: 1'b0};
    req_ready = 1'b0;
    case (state)
      S_INIT: begin
        cmd.act = ACT_INIT_WR;
        if (stat.init_last) begin
          cmd.cur_sel = CUR_ZERO;
          state_next = S_IDLE;
        end else begin
          cmd.cur_sel = CUR_INC;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.ld_op = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.mode)
          MODE_INSERT: begin
            if (stat.full) begin
              cmd.res_ld = 1'b1;
              cmd.res_st = ST_FULL;
              state_next = S_FINISH;
            end else begin
              cmd.cur_sel = CUR_FREE;
              state_next = S_ALLOC;
            end
          end
          MODE_POP, MODE_PEEK: begin
            if (stat.empty) begin
              cmd.res_ld = 1'b1;
              cmd.res_st = ST_EMPTY;
              state_next = S_FINISH;
            end else begin
              cmd.cur_sel = CUR_HEAD;
              state_next = S_HEAD;
            end
          end
          MODE_POP_MATCH, MODE_FIND_MATCH: begin
            if (stat.empty) begin
              cmd.res_ld = 1'b1;
              cmd.res_st = ST_EMPTY;
              state_next = S_FINISH;
            end else begin
              cmd.cur_sel = CUR_HEAD;
              cmd.walk_start = 1'b1;
              state_next = S_MATCH;
            end
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_ALLOC: begin
        cmd.act = ACT_ALLOC;
        if (stat.empty) begin
          state_next = S_FIRST;
        end else if (!stat.ordering) begin
          state_next = S_APPEND;
        end else begin
          cmd.cur_sel = CUR_HEAD;
          cmd.walk_start = 1'b1;
          state_next = S_ORD_WALK;
        end
      end
      S_FIRST: begin
        cmd.act = ACT_FIRST;
        state_next = S_FINISH;
      end
      S_APPEND: begin
        cmd.act = ACT_APPEND;
        state_next = S_FINISH;
      end
      S_ORD_WALK: begin
        if (stat.key_gt) begin
          cmd.act = ACT_ORD_STOP;
          state_next = stat.have_prev ? S_ORD_LINK : S_FINISH;
        end else if (stat.last) begin
          state_next = S_APPEND;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.cur_sel = CUR_LINK;
        end
      end
      S_ORD_LINK: begin
        cmd.act = ACT_ORD_LINK;
        state_next = S_FINISH;
      end
      S_HEAD: begin
        cmd.res_cap = 1'b1;
        if (stat.mode == MODE_POP) begin
          cmd.act = ACT_POP;
        end
        state_next = S_FINISH;
      end
      S_MATCH: begin
        if (stat.data_eq) begin
          cmd.res_cap = 1'b1;
          if (stat.mode == MODE_POP_MATCH) begin
            cmd.act = ACT_MATCH_HIT;
            state_next = S_MATCH_FREE;
          end else begin
            state_next = S_FINISH;
          end
        end else if (stat.last) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ST_NOMATCH;
          state_next = S_FINISH;
        end else begin
          cmd.walk_step = 1'b1;
          cmd.cur_sel = CUR_LINK;
        end
      end
      S_MATCH_FREE: begin
        cmd.act = ACT_MATCH_FREE;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

>>> rtl/oq_dpath.sv
// entry memories, list pointers, walk registers and result register
module oq_dpath import oq_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_wr_data,
  input  logic [2:0]                in_mode,
  input  logic signed [FIELD_W-1:0] in_key,
  input  logic [FIELD_W-1:0]        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                out_status,
  output logic signed [FIELD_W-1:0] out_key,
  output logic [FIELD_W-1:0]        out_data,
  output logic [COUNT_W-1:0]        out_count
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] key_mem  [CAPACITY];
  logic [FIELD_W-1:0]   data_mem [CAPACITY];
  logic [IDX_W-1:0]     link_mem [CAPACITY];

  logic [KEY_WIDTH-1:0] rd_key;
  logic [FIELD_W-1:0]   rd_data;
  logic [IDX_W-1:0]     rd_link;

  logic                 ordering;
  mode_t                op_mode;
  logic [KEY_WIDTH-1:0] op_key;
  logic [FIELD_W-1:0]   op_data;
  logic [KEY_WIDTH-1:0] key_ext;

  logic [IDX_W-1:0] cur, cur_next, prev, head, tail, free_head, new_slot;
  logic             have_prev;
  logic [CNT_W-1:0] count, walk_i;

  status_t              res_st;
  logic [KEY_WIDTH-1:0] res_key;
  logic [FIELD_W-1:0]   res_data;

  logic             kv_we, link_we;
  logic [IDX_W-1:0] link_waddr, link_wdata;

  // key sizing between the port and the stored width
  if (KEY_WIDTH > FIELD_W) begin : g_key_wide
    assign key_ext = {{(KEY_WIDTH - FIELD_W){in_key[FIELD_W-1]}}, in_key};
  end
  else begin : g_key_narrow
    assign key_ext = in_key[KEY_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ordering <= 1'b0;
    end else if (cfg_wr_en) begin
      ordering <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      op_mode <= mode_t'(in_mode);
      op_key  <= key_ext;
      op_data <= in_data;
    end
  end

  always_comb begin
    case (cmd.cur_sel)
      CUR_ZERO: cur_next = '0;
      CUR_INC:  cur_next = cur + 1'b1;
      CUR_HEAD: cur_next = head;
      CUR_FREE: cur_next = free_head;
      CUR_LINK: cur_next = rd_link;
      default:  cur_next = cur;
    endcase
  end

  // link memory write port
  always_comb begin
    kv_we      = 1'b0;
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = '0;
    case (cmd.act)
      ACT_INIT_WR: begin
        link_we    = 1'b1;
        link_wdata = (cur == IDX_W'(CAPACITY - 1)) ? '0 : cur + 1'b1;
      end
      ACT_ALLOC: begin
        kv_we   = 1'b1;
        link_we = 1'b1;
      end
      ACT_APPEND: begin
        link_we    = 1'b1;
        link_waddr = tail;
        link_wdata = new_slot;
      end
      ACT_ORD_STOP: begin
        link_we    = 1'b1;
        link_waddr = new_slot;
        link_wdata = cur;
      end
      ACT_ORD_LINK: begin
        link_we    = 1'b1;
        link_waddr = prev;
        link_wdata = new_slot;
      end
      ACT_POP, ACT_MATCH_FREE: begin
        link_we    = 1'b1;
        link_wdata = free_head;
      end
      ACT_MATCH_HIT: begin
        link_we    = have_prev;
        link_waddr = prev;
        link_wdata = rd_link;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[cur] <= op_key;
    end
    rd_key <= key_mem[cur_next];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      data_mem[cur] <= op_data;
    end
    rd_data <= data_mem[cur_next];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[cur_next];
  end

  // list pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      head      <= '0;
      tail      <= '0;
      free_head <= '0;
      count     <= '0;
    end else begin
      cur <= cur_next;
      case (cmd.act)
        ACT_ALLOC: begin
          free_head <= rd_link;
        end
        ACT_FIRST: begin
          head  <= new_slot;
          tail  <= new_slot;
          count <= CNT_W'(1);
        end
        ACT_APPEND: begin
          tail  <= new_slot;
          count <= count + 1'b1;
        end
        ACT_ORD_STOP: begin
          if (!have_prev) begin
            head <= new_slot;
          end
          count <= count + 1'b1;
        end
        ACT_POP: begin
          free_head <= cur;
          count     <= count - 1'b1;
          if (count == CNT_W'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= rd_link;
          end
        end
        ACT_MATCH_HIT: begin
          if (!have_prev) begin
            head <= rd_link;
          end
          if (cur == tail) begin
            tail <= prev;
          end
          count <= count - 1'b1;
        end
        ACT_MATCH_FREE: begin
          free_head <= cur;
          if (count == '0) begin
            head <= '0;
            tail <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_ALLOC) begin
      new_slot <= cur;
    end
    if (cmd.walk_start) begin
      prev      <= '0;
      have_prev <= 1'b0;
      walk_i    <= '0;
    end else if (cmd.walk_step) begin
      prev      <= cur;
      have_prev <= 1'b1;
      walk_i    <= walk_i + 1'b1;
    end
  end

  // result of the current operation
  always_ff @(posedge clk) begin
    if (cmd.ld_op) begin
      res_st   <= ST_OK;
      res_key  <= '0;
      res_data <= '0;
    end else begin
      if (cmd.res_ld) begin
        res_st <= cmd.res_st;
      end
      if (cmd.res_cap) begin
        res_key  <= rd_key;
        res_data <= rd_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_status <= res_st;
      out_data   <= res_data;
    end
  end

  if (KEY_WIDTH >= FIELD_W) begin : g_fkey_trunc
    always_ff @(posedge clk) begin
      if (cmd.out_ld) begin
        out_key <= res_key[FIELD_W-1:0];
      end
    end
  end
  else begin : g_fkey_ext
    always_ff @(posedge clk) begin
      if (cmd.out_ld) begin
        out_key <= {{(FIELD_W - KEY_WIDTH){1'b0}}, res_key};
      end
    end
  end

  if (CNT_W >= COUNT_W) begin : g_cnt_trunc
    always_ff @(posedge clk) begin
      if (cmd.out_ld) begin
        out_count <= count[COUNT_W-1:0];
      end
    end
  end
  else begin : g_cnt_ext
    always_ff @(posedge clk) begin
      if (cmd.out_ld) begin
        out_count <= {{(COUNT_W - CNT_W){1'b0}}, count};
      end
    end
  end

  always_comb begin
    stat.mode      = op_mode;
    stat.full      = (count == CNT_W'(CAPACITY));
    stat.empty     = (count == '0);
    stat.ordering  = ordering;
    stat.key_gt    = ($signed(rd_key) > $signed(op_key));
    stat.data_eq   = (rd_data == op_data);
    stat.last      = ((walk_i + 1'b1) == count);
    stat.init_last = (cur == IDX_W'(CAPACITY - 1));
    stat.have_prev = have_prev;
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

>>> rtl/ordered_or_fifo_queue.sv
// top level of the bounded ordered or first-in first-out queue
// Bounded queue of (key, data) entries held as a linked list in CAPACITY
// slots with a free list. With ordering at 0 inserts append; with ordering
// at 1 an insert lands after every entry whose signed key is less than or
// equal to its own, so equal keys keep arrival order. Each request transfer
// yields exactly one response transfer carrying status, the key and data of
// the removed or found entry (zero otherwise) and the entry count after the
// operation. Work is one request at a time: a request is taken only while
// the sequencer is idle. An ordered insert or a match search walks the list
// at one entry per cycle through the registered memory read port. A stalled
// response holds the sequencer in its finish state until the response
// register is free. After reset the link memory is chained by a pass over
// all CAPACITY slots during which no request is taken; configuration writes
// are taken at any time and are meant to happen while the queue is idle.
module ordered_or_fifo_queue import oq_pkg::*; #(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_wr_en,
  input  logic    cfg_wr_data,
  oq_req_if.sink  req,
  oq_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: walks, pointer updates and the result hand-off
  oq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // memories, list pointers and the response register
  oq_dpath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (req.mode),
    .in_key      (req.key),
    .in_data     (req.item_data),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_key     (rsp.found_key),
    .out_data    (rsp.found_data),
    .out_count   (rsp.entry_count)
  );

endmodule
